// ===== src/lpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared widths and the decoded command word of the line point rasterizer.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int COORD_W = 11;
  localparam int SPAN_W  = 12;
  localparam int ERR_W   = 14;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef struct packed {
    logic                is_start;
    logic                degenerate;
    logic                major_is_y;
    logic                major_dir;
    logic                minor_dir;
    logic [COORD_W-1:0]  cur_major;
    logic [COORD_W-1:0]  cur_minor;
    logic [SPAN_W-1:0]   major_span;
    logic [SPAN_W-1:0]   minor_span;
  } cmd_t;

endpackage
`default_nettype wire

// ===== src/lpr_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_in_if
// Input channel: action word with segment endpoints.
// ----------------------------------------------------------------------------
interface lpr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [10:0] start_x;
  logic [10:0] start_y;
  logic [10:0] end_x;
  logic [10:0] end_y;

  modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

// ===== src/lpr_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_out_if
// Result channel: one emitted point word.
// ----------------------------------------------------------------------------
interface lpr_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] point_x;
  logic [10:0] point_y;
  logic        point_valid;
  logic        last_point;

  modport source (output valid, point_x, point_y, point_valid, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_valid, last_point, output ready);
endinterface
`default_nettype wire

// ===== src/lpr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_front
// Classifies an input word: saturates endpoints, picks the major axis,
// directions and spans, and builds the command for the back end.
// ----------------------------------------------------------------------------
module lpr_front
  import lpr_pkg::*;
#(
  parameter int COORD_MAX = 2047
) (
  input  wire logic               action,
  input  wire logic [COORD_W-1:0] start_x,
  input  wire logic [COORD_W-1:0] start_y,
  input  wire logic [COORD_W-1:0] end_x,
  input  wire logic [COORD_W-1:0] end_y,
  output cmd_t                    cmd
);

  logic [COORD_W-1:0] sx, sy, ex, ey;
  logic [COORD_W-1:0] adx, ady;
  logic               from_start;

  function automatic logic [COORD_W-1:0] sat(input logic [COORD_W-1:0] c);
    logic [COORD_W-1:0] r;
    r = c;
    if (32'(c) > COORD_MAX) r = COORD_W'(COORD_MAX);
    return r;
  endfunction

  always_comb begin
    sx = sat(start_x);
    sy = sat(start_y);
    ex = sat(end_x);
    ey = sat(end_y);
    adx = (sx > ex) ? sx - ex : ex - sx;
    ady = (sy > ey) ? sy - ey : ey - sy;
    from_start = sx < ex;

    cmd            = '0;
    cmd.is_start   = (action == ACT_START);
    cmd.degenerate = (adx == '0) && (ady == '0);
    priority if (adx == '0) begin
      // vertical, lower row first
      cmd.major_is_y = 1'b1;
      cmd.cur_major  = (sy < ey) ? sy : ey;
      cmd.cur_minor  = sx;
      cmd.major_span = SPAN_W'(ady);
      cmd.minor_span = '0;
    end else if ((ady == '0) || (ady == adx)) begin
      // horizontal or diagonal, lower column first
      cmd.major_is_y = 1'b0;
      cmd.minor_dir  = from_start ? (ey < sy) : (sy < ey);
      cmd.cur_major  = from_start ? sx : ex;
      cmd.cur_minor  = from_start ? sy : ey;
      cmd.major_span = SPAN_W'(adx);
      cmd.minor_span = SPAN_W'(ady);
    end else if (ady > adx) begin
      cmd.major_is_y = 1'b1;
      cmd.major_dir  = ey < sy;
      cmd.minor_dir  = ex < sx;
      cmd.cur_major  = sy;
      cmd.cur_minor  = sx;
      cmd.major_span = SPAN_W'(ady);
      cmd.minor_span = SPAN_W'(adx);
    end else begin
      cmd.major_is_y = 1'b0;
      cmd.major_dir  = ex < sx;
      cmd.minor_dir  = ey < sy;
      cmd.cur_major  = sx;
      cmd.cur_minor  = sy;
      cmd.major_span = SPAN_W'(adx);
      cmd.minor_span = SPAN_W'(ady);
    end
  end

endmodule
`default_nettype wire

// ===== src/lpr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_queue
// Short command queue between the classifier and the stepping engine.
// ----------------------------------------------------------------------------
module lpr_queue
  import lpr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      not_empty
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
    else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");

endmodule
`default_nettype wire

// ===== src/lpr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_back
// Stepping engine: holds the segment state, advances one point per command
// and drives the registered result word.
// ----------------------------------------------------------------------------
module lpr_back
  import lpr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cmd_avail,
  input  wire cmd_t       cmd,
  output logic            cmd_take,
  lpr_out_if.source       out_ch
);

  logic               active_r;
  logic [SPAN_W-1:0]  steps_left_r;
  logic [COORD_W-1:0] cur_major_r, cur_minor_r;
  logic               major_is_y_r, major_dir_r, minor_dir_r;
  logic [SPAN_W-1:0]  maj_span_r, min_span_r;
  logic [ERR_W-1:0]   err_r;

  logic               out_valid_r;
  logic [COORD_W-1:0] point_x_r, point_y_r;
  logic               point_valid_r, last_r;

  logic [COORD_W-1:0] major_nxt, minor_nxt;
  logic [ERR_W-1:0]   err_sum, err_nxt;
  logic [SPAN_W-1:0]  steps_nxt;
  logic               minor_step, can_step;

  assign cmd_take = cmd_avail && (!out_valid_r || out_ch.ready);
  assign can_step = active_r && (steps_left_r != '0);

  always_comb begin
    major_nxt  = major_dir_r ? cur_major_r - 1'b1 : cur_major_r + 1'b1;
    err_sum    = err_r + ERR_W'({min_span_r, 1'b0});
    minor_step = err_sum >= ERR_W'({maj_span_r, 1'b0});
    err_nxt    = minor_step ? err_sum - ERR_W'({maj_span_r, 1'b0}) : err_sum;
    minor_nxt  = cur_minor_r;
    if (minor_step) minor_nxt = minor_dir_r ? cur_minor_r - 1'b1 : cur_minor_r + 1'b1;
    steps_nxt  = steps_left_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      steps_left_r  <= '0;
      out_valid_r   <= 1'b0;
      cur_major_r   <= '0;
      cur_minor_r   <= '0;
      major_is_y_r  <= 1'b0;
      major_dir_r   <= 1'b0;
      minor_dir_r   <= 1'b0;
      maj_span_r    <= '0;
      min_span_r    <= '0;
      err_r         <= '0;
      point_x_r     <= '0;
      point_y_r     <= '0;
      point_valid_r <= 1'b0;
      last_r        <= 1'b0;
    end else begin
      if (cmd_take) begin
        out_valid_r <= 1'b1;
        if (cmd.is_start) begin
          if (cmd.degenerate) begin
            active_r      <= 1'b0;
            steps_left_r  <= '0;
            point_x_r     <= '0;
            point_y_r     <= '0;
            point_valid_r <= 1'b0;
            last_r        <= 1'b0;
          end else begin
            active_r      <= 1'b1;
            steps_left_r  <= cmd.major_span;
            cur_major_r   <= cmd.cur_major;
            cur_minor_r   <= cmd.cur_minor;
            major_is_y_r  <= cmd.major_is_y;
            major_dir_r   <= cmd.major_dir;
            minor_dir_r   <= cmd.minor_dir;
            maj_span_r    <= cmd.major_span;
            min_span_r    <= cmd.minor_span;
            err_r         <= ERR_W'(cmd.major_span) - ERR_W'(cmd.minor_dir);
            point_valid_r <= 1'b1;
            last_r        <= 1'b0;
            point_x_r     <= cmd.major_is_y ? cmd.cur_minor : cmd.cur_major;
            point_y_r     <= cmd.major_is_y ? cmd.cur_major : cmd.cur_minor;
          end
        end else if (!can_step) begin
          active_r      <= 1'b0;
          point_x_r     <= '0;
          point_y_r     <= '0;
          point_valid_r <= 1'b0;
          last_r        <= 1'b0;
        end else begin
          cur_major_r   <= major_nxt;
          cur_minor_r   <= minor_nxt;
          err_r         <= err_nxt;
          steps_left_r  <= steps_nxt;
          active_r      <= (steps_nxt != '0);
          point_valid_r <= 1'b1;
          last_r        <= (steps_nxt == '0);
          point_x_r     <= major_is_y_r ? minor_nxt : major_nxt;
          point_y_r     <= major_is_y_r ? major_nxt : minor_nxt;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.point_x     = point_x_r;
  assign out_ch.point_y     = point_y_r;
  assign out_ch.point_valid = point_valid_r;
  assign out_ch.last_point  = last_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !point_valid_r) |->
      (point_x_r == '0 && point_y_r == '0 && !last_r))
    else $error("invalid result word carries nonzero fields");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> !active_r)
    else $error("segment still active after its last point");
  a_active_steps: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (steps_left_r != '0))
    else $error("active segment with no steps left");

endmodule
`default_nettype wire

// ===== src/line_point_rasterizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_point_rasterizer_core
// Line rasterizer: start words load a segment, step words pull the next
// point; exact half-up minor coordinate from an integer error term.
// ----------------------------------------------------------------------------
// Each accepted word is queued, then registered as the result word on out_ch.
// Throughput: one word per cycle while out_ch is ready; the stepping engine holds
// on output stalls, and a 2-entry command queue decouples the classifier from them.
// Reset: no active segment, queue empty, no result pending.
// ----------------------------------------------------------------------------
module line_point_rasterizer_core
  import lpr_pkg::*;
#(
  parameter int COORD_MAX = 2047
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lpr_in_if.sink    in_ch,
  lpr_out_if.source out_ch
);

  cmd_t front_cmd, q_cmd;
  logic q_full, q_not_empty, q_pop, push;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  lpr_front #(.COORD_MAX(COORD_MAX)) u_front (
    .action  (in_ch.action),
    .start_x (in_ch.start_x),
    .start_y (in_ch.start_y),
    .end_x   (in_ch.end_x),
    .end_y   (in_ch.end_y),
    .cmd     (front_cmd)
  );

  lpr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_cmd),
    .not_empty (q_not_empty)
  );

  lpr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_avail (q_not_empty),
    .cmd       (q_cmd),
    .cmd_take  (q_pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line point rasterizer core. Drives start and
// step words with random gaps and long output stalls. A local rasterizer
// model computes each expected point word, and the checker compares the
// returned point words with the queue of expected points, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import lpr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int COORD_TOP      = 2047;

  typedef struct {
    action_t            action;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
  } seg_word_t;

  typedef struct {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               pv;
    logic               lp;
  } point_word_t;

  logic clk;
  logic rst_n;

  lpr_in_if  in_ch ();
  lpr_out_if out_ch ();

  line_point_rasterizer_core #(
    .COORD_MAX (COORD_TOP)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // rasterizer model state
  logic               seg_active   = 1'b0;
  logic [COORD_W-1:0] seg_major    = '0;
  logic [COORD_W-1:0] seg_minor    = '0;
  logic               seg_major_y  = 1'b0;
  logic [SPAN_W-1:0]  seg_left     = '0;
  logic               seg_major_dn = 1'b0;
  logic               seg_minor_dn = 1'b0;
  logic [SPAN_W-1:0]  seg_span_a   = '0;
  logic [SPAN_W-1:0]  seg_span_b   = '0;
  logic [ERR_W-1:0]   seg_err      = '0;

  point_word_t pending_points[$];
  point_word_t exp_pt;
  int          fail_count  = 0;
  int          words_sent  = 0;
  int          idle_cycles = 0;
  bit          tx_gaps     = 1'b0;
  bit          rx_gaps     = 1'b0;
  int          rx_hold_req = 0;
  int          rx_wait     = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic point_word_t next_point(input seg_word_t w);
    point_word_t r;
    int sx, sy, ex, ey, adx, ady, e;
    logic pv, lp;
    r  = '{default: '0};
    pv = 1'b0;
    lp = 1'b0;
    if (w.action == ACT_START) begin
      sx  = (w.sx > COORD_TOP) ? COORD_TOP : int'(w.sx);
      sy  = (w.sy > COORD_TOP) ? COORD_TOP : int'(w.sy);
      ex  = (w.ex > COORD_TOP) ? COORD_TOP : int'(w.ex);
      ey  = (w.ey > COORD_TOP) ? COORD_TOP : int'(w.ey);
      adx = (sx > ex) ? sx - ex : ex - sx;
      ady = (sy > ey) ? sy - ey : ey - sy;
      if (adx == 0 && ady == 0) begin
        seg_active = 1'b0;
        seg_left   = '0;
      end else begin
        if (adx == 0) begin
          // vertical: lower row first
          seg_major_y  = 1'b1;
          seg_major_dn = 1'b0;
          seg_minor_dn = 1'b0;
          seg_major    = COORD_W'((sy < ey) ? sy : ey);
          seg_minor    = COORD_W'(sx);
          seg_span_a   = SPAN_W'(ady);
          seg_span_b   = '0;
        end else if (ady == 0 || ady == adx) begin
          // horizontal or diagonal: lower column first
          seg_major_y  = 1'b0;
          seg_major_dn = 1'b0;
          seg_minor_dn = (sx < ex) ? (ey < sy) : (sy < ey);
          seg_major    = COORD_W'((sx < ex) ? sx : ex);
          seg_minor    = COORD_W'((sx < ex) ? sy : ey);
          seg_span_a   = SPAN_W'(adx);
          seg_span_b   = SPAN_W'(ady);
        end else if (ady > adx) begin
          seg_major_y  = 1'b1;
          seg_major_dn = ey < sy;
          seg_minor_dn = ex < sx;
          seg_major    = COORD_W'(sy);
          seg_minor    = COORD_W'(sx);
          seg_span_a   = SPAN_W'(ady);
          seg_span_b   = SPAN_W'(adx);
        end else begin
          seg_major_y  = 1'b0;
          seg_major_dn = ex < sx;
          seg_minor_dn = ey < sy;
          seg_major    = COORD_W'(sx);
          seg_minor    = COORD_W'(sy);
          seg_span_a   = SPAN_W'(adx);
          seg_span_b   = SPAN_W'(ady);
        end
        seg_err    = ERR_W'(seg_span_a) - ERR_W'(seg_minor_dn);
        seg_left   = seg_span_a;
        seg_active = 1'b1;
        pv         = 1'b1;
      end
    end else if (!seg_active || seg_left == 0) begin
      seg_active = 1'b0;
    end else begin
      seg_major = seg_major_dn ? seg_major - 1'b1 : seg_major + 1'b1;
      e = int'(seg_err) + 2 * int'(seg_span_b);
      if (e >= 2 * int'(seg_span_a)) begin
        e         = e - 2 * int'(seg_span_a);
        seg_minor = seg_minor_dn ? seg_minor - 1'b1 : seg_minor + 1'b1;
      end
      seg_err  = e[ERR_W-1:0];
      seg_left = seg_left - 1'b1;
      if (seg_left == 0) seg_active = 1'b0;
      pv = 1'b1;
      lp = (seg_left == 0);
    end
    if (pv) begin
      r.px = seg_major_y ? seg_minor : seg_major;
      r.py = seg_major_y ? seg_major : seg_minor;
      r.pv = 1'b1;
      r.lp = lp;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d (t=%0t)", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic send_word(input seg_word_t w);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.action  <= w.action;
    in_ch.start_x <= w.sx;
    in_ch.start_y <= w.sy;
    in_ch.end_x   <= w.ex;
    in_ch.end_y   <= w.ey;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_points.insert(pending_points.size(), next_point(w));
    words_sent++;
    gap = (tx_gaps && $urandom_range(99) < 30) ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic start_seg(input int sx, input int sy, input int ex, input int ey);
    seg_word_t w;
    w.action = ACT_START;
    w.sx     = COORD_W'(sx);
    w.sy     = COORD_W'(sy);
    w.ex     = COORD_W'(ex);
    w.ey     = COORD_W'(ey);
    send_word(w);
  endtask

  // endpoint fields are don't-care on a step, so fill them at random
  task automatic step_word();
    seg_word_t w;
    w.action = ACT_STEP;
    w.sx     = COORD_W'($urandom_range(COORD_TOP));
    w.sy     = COORD_W'($urandom_range(COORD_TOP));
    w.ex     = COORD_W'($urandom_range(COORD_TOP));
    w.ey     = COORD_W'($urandom_range(COORD_TOP));
    send_word(w);
  endtask

  task automatic wait_all_points();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
  endtask

  task automatic run_segment(input int max_span);
    int sx, sy, ex, ey, dx, dy, shape, major, steps, pick;
    sx    = $urandom_range(COORD_TOP);
    sy    = $urandom_range(COORD_TOP);
    dx    = $urandom_range(max_span);
    dy    = $urandom_range(max_span);
    shape = $urandom_range(9);
    if (shape == 0) dx = 0;
    else if (shape == 1) dy = 0;
    else if (shape == 2) dy = dx;
    ex = $urandom_range(1) ? sx + dx : sx - dx;
    ey = $urandom_range(1) ? sy + dy : sy - dy;
    if (ex < 0) ex = 0;
    if (ex > COORD_TOP) ex = COORD_TOP;
    if (ey < 0) ey = 0;
    if (ey > COORD_TOP) ey = COORD_TOP;
    dx    = (ex > sx) ? ex - sx : sx - ex;
    dy    = (ey > sy) ? ey - sy : sy - ey;
    major = (dx > dy) ? dx : dy;
    pick  = $urandom_range(9);
    if (pick < 7) steps = major;
    else if (pick < 9) steps = major + $urandom_range(2, 1);
    else steps = $urandom_range(major);
    // long segments get abandoned early by the next start
    if (steps > 60) steps = $urandom_range(60, 20);
    start_seg(sx, sy, ex, ey);
    repeat (steps) step_word();
  endtask

  task automatic test_idle_and_degenerate();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    step_word();
    start_seg(0, 0, 0, 0);
    step_word();
    start_seg(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP);
    wait_all_points();
  endtask

  task automatic test_directed_shapes();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    start_seg(0, 0, COORD_TOP, COORD_TOP);
    repeat (2) step_word();
    start_seg(COORD_TOP, 0, 0, COORD_TOP);
    step_word();
    start_seg(5, COORD_TOP, 5, 0);
    step_word();
    start_seg(COORD_TOP, 3, 0, 3);
    step_word();
    // shallow slope with a rounding tie, stepped past its end
    start_seg(0, 0, 4, 1);
    repeat (5) step_word();
    start_seg(3, 0, 0, 4);
    repeat (2) step_word();
    start_seg(COORD_TOP, COORD_TOP, 0, COORD_TOP - 1);
    step_word();
    wait_all_points();
  endtask

  task automatic test_backpressure();
    tx_gaps     = 1'b0;
    rx_gaps     = 1'b0;
    rx_hold_req = 150;
    start_seg(100, 200, 160, 230);
    repeat (45) step_word();
    wait_all_points();
  endtask

  task automatic test_drain_pause();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    start_seg(1000, 40, 970, 10);
    repeat (10) step_word();
    wait_all_points();
    repeat (22) step_word();
    wait_all_points();
  endtask

  task automatic test_random_segments();
    int span_pick;
    while (words_sent < 1800) begin
      tx_gaps   = ($urandom_range(6) != 0);
      rx_gaps   = ($urandom_range(6) != 0);
      span_pick = $urandom_range(99);
      if (span_pick < 85) run_segment($urandom_range(16, 1));
      else if (span_pick < 97) run_segment($urandom_range(100, 17));
      else run_segment(COORD_TOP);
    end
    wait_all_points();
  endtask

  task automatic test_noise();
    seg_word_t w;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    repeat (200) begin
      w.action = ($urandom_range(99) < 30) ? ACT_START : ACT_STEP;
      w.sx     = COORD_W'($urandom_range(COORD_TOP));
      w.sy     = COORD_W'($urandom_range(COORD_TOP));
      w.ex     = COORD_W'($urandom_range(COORD_TOP));
      w.ey     = COORD_W'($urandom_range(COORD_TOP));
      send_word(w);
    end
    wait_all_points();
  endtask

  // receiver: random stalls, plus long holds on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (rx_hold_req > 0) begin
        rx_wait     = rx_hold_req;
        rx_hold_req = 0;
      end else if (rx_wait == 0 && rx_gaps && $urandom_range(99) < 30) begin
        rx_wait = pick_gap();
      end
      if (rx_wait > 0) begin
        out_ch.ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("point word with none pending", int'(out_ch.point_x), 0);
      end else begin
        exp_pt = pending_points.pop_front();
        if (out_ch.point_x !== exp_pt.px)
          report_mismatch("point_x", int'(out_ch.point_x), int'(exp_pt.px));
        if (out_ch.point_y !== exp_pt.py)
          report_mismatch("point_y", int'(out_ch.point_y), int'(exp_pt.py));
        if (out_ch.point_valid !== exp_pt.pv)
          report_mismatch("point_valid", int'(out_ch.point_valid), int'(exp_pt.pv));
        if (out_ch.last_point !== exp_pt.lp)
          report_mismatch("last_point", int'(out_ch.last_point), int'(exp_pt.lp));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= ACT_START;
    in_ch.start_x <= '0;
    in_ch.start_y <= '0;
    in_ch.end_x   <= '0;
    in_ch.end_y   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_and_degenerate();
    test_directed_shapes();
    test_backpressure();
    test_drain_pause();
    test_random_segments();
    test_noise();
    wait_all_points();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
